FILE: rtl/core/spop_pkg.sv
// Package: shared types, packet layout constants, CORDIC angle table and gain function.
`default_nettype none
package spop_pkg;

    localparam int PacketBytes = 26;
    localparam int PosSat      = 31;
    localparam int TabLen      = 24;

    // Arctangent of 2^-i in units of 2^32 per full turn.
    localparam logic [31:0] ATAN_TAB [TabLen] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef enum logic [2:0] {
        ST_RECV,
        ST_DIV,
        ST_HEAD,
        ST_ROT,
        ST_MUL,
        ST_DONE
    } t_state;

    // Restoring long division, evaluated at elaboration only.
    function automatic longint unsigned spop_udiv(input longint unsigned n,
                                                  input longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        int i;
        q = 64'd0;
        r = 64'd0;
        for (i = 63; i >= 0; i--) begin
            r = (r << 1) | ((n >> i) & 64'd1);
            if (r >= d) begin
                r = r - d;
                q = q | (64'd1 << i);
            end
        end
        return q;
    endfunction

    // CORDIC gain in Q31, evaluated at elaboration only.
    function automatic longint unsigned spop_gain(input int steps);
        longint unsigned kk;
        longint unsigned v;
        longint unsigned r;
        longint unsigned b;
        int i;
        kk = 64'd1 << 62;
        for (i = 0; i < steps; i++) begin
            kk = kk - spop_udiv(kk, (64'd1 << (2 * i)) + 64'd1);
        end
        v = kk;
        r = 64'd0;
        b = 64'd1 << 62;
        for (i = 0; i < 32; i++) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/spop_if.sv
// Interfaces: the byte input channel and the result output channel.
`default_nettype none
interface spop_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       end_of_packet;

    modport source (output valid, output rx_byte, output end_of_packet, input ready);
    modport sink   (input valid, input rx_byte, input end_of_packet, output ready);
endinterface

interface spop_res_if;
    logic               valid;
    logic               ready;
    logic               status;
    logic [10:0]        contact_flags;
    logic [8:0]         motor_button_flags;
    logic [7:0]         remote_code;
    logic [7:0]         charge_status;
    logic [15:0]        battery_millivolts;
    logic signed [15:0] battery_milliamps;
    logic signed [7:0]  battery_temp;
    logic [31:0]        charge_and_capacity;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [15:0] pose_heading;

    modport source (output valid, output status, output contact_flags,
                    output motor_button_flags, output remote_code, output charge_status,
                    output battery_millivolts, output battery_milliamps,
                    output battery_temp, output charge_and_capacity,
                    output pose_x, output pose_y, output pose_heading, input ready);
    modport sink   (input valid, input status, input contact_flags,
                    input motor_button_flags, input remote_code, input charge_status,
                    input battery_millivolts, input battery_milliamps,
                    input battery_temp, input charge_and_capacity,
                    input pose_x, input pose_y, input pose_heading, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/spop_cordic.sv
// Iterative CORDIC rotation giving cos and sin of a binary-angle heading in Q31.
`default_nettype none
module spop_cordic
    import spop_pkg::*;
#(
    parameter int STEPS = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  wire  [15:0]         i_heading,
    output logic                o_done,
    output logic signed [32:0]  o_cos,
    output logic signed [32:0]  o_sin
);
    localparam int IW = $clog2(STEPS);
    localparam logic signed [32:0] KInit = 33'(spop_gain(STEPS));
    localparam logic signed [32:0] Quarter = 33'sh040000000;
    localparam logic signed [32:0] Half    = 33'sh080000000;

    logic signed [32:0] r_x, r_y, r_z;
    logic [IW-1:0]      r_i;
    logic               r_neg;
    logic               r_busy;
    logic               r_fin;
    logic               r_done;
    logic signed [32:0] r_cos, r_sin;

    logic signed [32:0] z0;
    logic signed [32:0] dx, dy, ang;

    assign z0  = {i_heading[15], i_heading, 16'b0};
    assign dx  = r_y >>> r_i;
    assign dy  = r_x >>> r_i;
    assign ang = {1'b0, ATAN_TAB[5'(r_i)]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_fin;
            r_fin  <= !i_start && r_busy && r_i == IW'(STEPS - 1);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_i == IW'(STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= KInit;
            r_y <= '0;
            r_i <= '0;
            // Fold the angle into the right half-plane and flip the result later.
            if (z0 > Quarter) begin
                r_z   <= z0 - Half;
                r_neg <= 1'b1;
            end else if (z0 < -Quarter) begin
                r_z   <= z0 + Half;
                r_neg <= 1'b1;
            end else begin
                r_z   <= z0;
                r_neg <= 1'b0;
            end
        end else if (r_busy) begin
            if (!r_z[32]) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - ang;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + ang;
            end
            r_i <= r_i + 1'b1;
        end
        if (r_fin) begin
            r_cos <= r_neg ? -r_x : r_x;
            r_sin <= r_neg ? -r_y : r_y;
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_cos;
    assign o_sin  = r_sin;

endmodule
`default_nettype wire

FILE: rtl/core/sensor_packet_odometry_parser_core.sv
// Sensor packet parser with dead reckoning: takes one packet word per cycle while receiving.
// The final word starts a 31-step serial divide, a CORDIC rotation, a 16-step serial
// multiply and a load of the result, in that order, the load once the output is free.
// A packet of wrong length skips the divide, rotation and multiply and goes straight to the load.
// Synchronous active-low reset clears the byte count, the pose and the output valid.
`default_nettype none
module sensor_packet_odometry_parser_core
    import spop_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    spop_rx_if.sink      i_rx,
    spop_res_if.source   o_res
);
    localparam logic [30:0] DivBias = 31'd540000045;
    localparam logic [15:0] DivOff  = 16'h8D80;
    localparam logic [7:0]  Divisor = 8'd90;

    t_state r_state, n_state;
    logic [4:0]         r_pos;
    logic [7:0]         r_pkt [PacketBytes];
    logic               r_bad;
    logic [15:0]        r_heading;
    logic signed [31:0] r_x, r_y;
    logic [30:0]        r_num;
    logic [6:0]         r_rem;
    logic [15:0]        r_q;
    logic [4:0]         r_cnt;
    logic [15:0]        r_dist;
    logic signed [48:0] r_mc_x, r_mc_y, r_acc_x, r_acc_y;
    logic               r_ov;

    logic rx_ready, rx_acc, out_load, cord_start, cord_done;
    logic signed [32:0] cord_cos, cord_sin;
    logic [7:0]         div_t;
    logic               div_bit;
    logic [15:0]        head_next;
    logic signed [31:0] x_next, y_next;
    logic signed [48:0] part_x, part_y;
    logic [30:0]        num0;

    spop_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (cord_start),
        .i_heading (head_next),
        .o_done    (cord_done),
        .o_cos     (cord_cos),
        .o_sin     (cord_sin)
    );

    assign rx_acc = i_rx.valid && rx_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_RECV: if (rx_acc && i_rx.end_of_packet) begin
                n_state = (r_pos == 5'(PacketBytes - 1)) ? ST_DIV : ST_DONE;
            end
            ST_DIV:  if (r_cnt == 5'd30) n_state = ST_HEAD;
            ST_HEAD: n_state = ST_ROT;
            ST_ROT:  if (cord_done) n_state = ST_MUL;
            ST_MUL:  if (r_cnt == 5'd15) n_state = ST_DONE;
            ST_DONE: if (out_load) n_state = ST_RECV;
            default: n_state = ST_RECV;
        endcase
    end

    always_comb begin
        rx_ready   = 1'b0;
        out_load   = 1'b0;
        cord_start = 1'b0;
        case (r_state)
            ST_RECV: rx_ready   = 1'b1;
            ST_HEAD: cord_start = 1'b1;
            ST_DONE: out_load   = !r_ov || o_res.ready;
            default: ;
        endcase
    end

    // Numerator of the rounded degree-to-binary-angle conversion, biased positive.
    assign num0 = 31'({{15{r_pkt[14][7]}}, r_pkt[14], r_pkt[15]} << 14) + DivBias;
    assign div_t   = {r_rem, r_num[30]};
    assign div_bit = div_t >= Divisor;
    assign head_next = r_heading + r_q - DivOff;
    assign part_x  = r_dist[0] ? r_mc_x : '0;
    assign part_y  = r_dist[0] ? r_mc_y : '0;
    assign x_next  = r_x + {{6{r_acc_x[48]}}, r_acc_x[48:23]};
    assign y_next  = r_y + {{6{r_acc_y[48]}}, r_acc_y[48:23]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_RECV;
            r_pos     <= '0;
            r_heading <= '0;
            r_x       <= '0;
            r_y       <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (rx_acc) begin
                if (i_rx.end_of_packet) begin
                    r_pos <= '0;
                end else if (r_pos != 5'(PosSat)) begin
                    r_pos <= r_pos + 1'b1;
                end
            end
            if (cord_start) r_heading <= head_next;
            if (out_load && !r_bad) begin
                r_x <= x_next;
                r_y <= y_next;
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_acc && r_pos < 5'(PacketBytes)) r_pkt[r_pos] <= i_rx.rx_byte;
        if (rx_acc && i_rx.end_of_packet) begin
            r_bad <= r_pos != 5'(PacketBytes - 1);
            r_num <= num0;
            r_rem <= '0;
            r_cnt <= '0;
        end
        case (r_state)
            ST_DIV: begin
                r_rem <= div_bit ? 7'(div_t - Divisor) : div_t[6:0];
                r_q   <= {r_q[14:0], div_bit};
                r_num <= {r_num[29:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
            end
            ST_ROT: if (cord_done) begin
                r_mc_x  <= 49'(cord_cos);
                r_mc_y  <= 49'(cord_sin);
                r_acc_x <= 49'sd4194304;
                r_acc_y <= 49'sd4194304;
                r_dist  <= {r_pkt[12], r_pkt[13]};
                r_cnt   <= '0;
            end
            ST_MUL: begin
                // The top bit of the distance carries negative weight.
                if (r_cnt == 5'd15) begin
                    r_acc_x <= r_acc_x - part_x;
                    r_acc_y <= r_acc_y - part_y;
                end else begin
                    r_acc_x <= r_acc_x + part_x;
                    r_acc_y <= r_acc_y + part_y;
                end
                r_mc_x <= r_mc_x <<< 1;
                r_mc_y <= r_mc_y <<< 1;
                r_dist <= {1'b0, r_dist[15:1]};
                r_cnt  <= r_cnt + 1'b1;
            end
            default: ;
        endcase
        if (out_load) begin
            o_res.status <= r_bad;
            o_res.pose_heading <= r_heading;
            o_res.pose_x <= r_bad ? r_x : x_next;
            o_res.pose_y <= r_bad ? r_y : y_next;
            if (r_bad) begin
                o_res.contact_flags       <= '0;
                o_res.motor_button_flags  <= '0;
                o_res.remote_code         <= '0;
                o_res.charge_status       <= '0;
                o_res.battery_millivolts  <= '0;
                o_res.battery_milliamps   <= '0;
                o_res.battery_temp        <= '0;
                o_res.charge_and_capacity <= '0;
            end else begin
                o_res.contact_flags <= {r_pkt[6][0], r_pkt[5][0], r_pkt[4][0], r_pkt[3][0],
                                        r_pkt[2][0], r_pkt[1][0], r_pkt[0][4:0]};
                o_res.motor_button_flags  <= {r_pkt[11][3:0], r_pkt[7][4:0]};
                o_res.remote_code         <= r_pkt[10];
                o_res.charge_status       <= r_pkt[16];
                o_res.battery_millivolts  <= {r_pkt[17], r_pkt[18]};
                o_res.battery_milliamps   <= {r_pkt[19], r_pkt[20]};
                o_res.battery_temp        <= r_pkt[21];
                o_res.charge_and_capacity <= {r_pkt[24], r_pkt[25], r_pkt[22], r_pkt[23]};
            end
        end
    end

    assign i_rx.ready  = rx_ready;
    assign o_res.valid = r_ov;

`ifndef SYNTHESIS
    a_eop_leaves_recv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rx.valid && i_rx.ready && i_rx.end_of_packet) |=> r_state != ST_RECV)
        else $error("final word did not start packet processing");
    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> r_state == ST_DONE)
        else $error("result loaded outside the completion state");
    a_bad_keeps_pose: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_bad) |=> (r_x == $past(r_x) && r_y == $past(r_y)))
        else $error("pose changed on a packet of wrong length");
    a_start_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cord_start |=> !cord_start && r_state == ST_ROT)
        else $error("rotation started twice for one packet");
`endif

endmodule
`default_nettype wire

FILE: bench/tb.sv
// Testbench for the sensor packet parser with dead reckoning: random and directed packets.
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import spop_pkg::*;

    localparam int Steps     = 16;
    localparam int WatchMax  = 3000;
    localparam int LongStall = 500;

    typedef struct packed {
        logic        status;
        logic [10:0] contact_flags;
        logic [8:0]  motor_button_flags;
        logic [7:0]  remote_code;
        logic [7:0]  charge_status;
        logic [15:0] battery_millivolts;
        logic [15:0] battery_milliamps;
        logic [7:0]  battery_temp;
        logic [31:0] charge_and_capacity;
        logic [31:0] pose_x;
        logic [31:0] pose_y;
        logic [15:0] pose_heading;
    } t_report;

    // Keeps its own copy of the packet buffer and pose, and the reports still owed.
    class odometry_board;
        logic [7:0]  bytes_in [PacketBytes];
        logic [4:0]  fill_pos;
        logic [15:0] heading;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        longint      gain;
        t_report     owed [$];
        int          errors;
        int          reports_seen;

        function new();
            longint unsigned k;
            longint unsigned root;
            int i;
            k = 64'd1 << 62;
            for (i = 0; i < Steps; i++) k = k - k / ((64'd1 << (2 * i)) + 64'd1);
            // Bitwise square root, most significant bit first.
            root = 0;
            for (i = 31; i >= 0; i--) begin
                if ((root | (64'd1 << i)) * (root | (64'd1 << i)) <= k) root |= 64'd1 << i;
            end
            gain = longint'(root);
            fill_pos = 0;
            heading = 0;
            pos_x = 0;
            pos_y = 0;
            errors = 0;
            reports_seen = 0;
        endfunction

        function void rotate(input logic [15:0] h, output longint c, output longint s);
            longint x, y, z, dx, dy;
            bit flip;
            int i;
            z = longint'($signed(h)) * 65536;
            x = gain;
            y = 0;
            flip = 0;
            // Fold the angle into the right half plane; CORDIC only converges there.
            if (z > (64'sd1 <<< 30)) begin
                z = z - (64'sd1 <<< 31);
                flip = 1;
            end else if (z < -(64'sd1 <<< 30)) begin
                z = z + (64'sd1 <<< 31);
                flip = 1;
            end
            for (i = 0; i < Steps; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x = x - dx;
                    y = y + dy;
                    z = z - longint'(ATAN_TAB[i]);
                end else begin
                    x = x + dx;
                    y = y - dy;
                    z = z + longint'(ATAN_TAB[i]);
                end
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function void note_byte(input logic [7:0] b, input logic eop);
            t_report r;
            longint travel, deg, delta, c, s;
            int k;
            if (fill_pos < PacketBytes) bytes_in[fill_pos] = b;
            if (!eop) begin
                if (fill_pos < PosSat) fill_pos++;
                return;
            end
            r = '0;
            if (fill_pos == PacketBytes - 1) begin
                travel = longint'($signed({bytes_in[12], bytes_in[13]}));
                deg = longint'($signed({bytes_in[14], bytes_in[15]}));
                delta = (deg * 16384 + 45 + 64'sd90 * 6000000) / 90 - 6000000;
                heading = heading + delta[15:0];
                rotate(heading, c, s);
                delta = (travel * c + (64'sd1 <<< 22)) >>> 23;
                pos_x = pos_x + delta[31:0];
                delta = (travel * s + (64'sd1 <<< 22)) >>> 23;
                pos_y = pos_y + delta[31:0];
                r.contact_flags[4:0] = bytes_in[0][4:0];
                r.contact_flags[5] = bytes_in[1][0];
                for (k = 0; k < 4; k++) r.contact_flags[6 + k] = bytes_in[2 + k][0];
                r.contact_flags[10] = bytes_in[6][0];
                r.motor_button_flags = {bytes_in[11][3:0], bytes_in[7][4:0]};
                r.remote_code = bytes_in[10];
                r.charge_status = bytes_in[16];
                r.battery_millivolts = {bytes_in[17], bytes_in[18]};
                r.battery_milliamps = {bytes_in[19], bytes_in[20]};
                r.battery_temp = bytes_in[21];
                r.charge_and_capacity = {bytes_in[24], bytes_in[25], bytes_in[22], bytes_in[23]};
            end else begin
                r.status = 1'b1;
            end
            fill_pos = 0;
            r.pose_x = pos_x;
            r.pose_y = pos_y;
            r.pose_heading = heading;
            owed.push_back(r);
        endfunction

        function void cmp(input string name, input logic [31:0] e, input logic [31:0] a);
            if (e !== a) begin
                errors++;
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, e, a);
            end
        endfunction

        function void check_report(input t_report a);
            t_report e;
            reports_seen++;
            if (owed.size() == 0) begin
                errors++;
                $display("%0t: unexpected report, expected none, got %h", $time, a);
                return;
            end
            e = owed.pop_front();
            cmp("status", e.status, a.status);
            cmp("contact_flags", e.contact_flags, a.contact_flags);
            cmp("motor_button_flags", e.motor_button_flags, a.motor_button_flags);
            cmp("remote_code", e.remote_code, a.remote_code);
            cmp("charge_status", e.charge_status, a.charge_status);
            cmp("battery_millivolts", e.battery_millivolts, a.battery_millivolts);
            cmp("battery_milliamps", e.battery_milliamps, a.battery_milliamps);
            cmp("battery_temp", e.battery_temp, a.battery_temp);
            cmp("charge_and_capacity", e.charge_and_capacity, a.charge_and_capacity);
            cmp("pose_x", e.pose_x, a.pose_x);
            cmp("pose_y", e.pose_y, a.pose_y);
            cmp("pose_heading", e.pose_heading, a.pose_heading);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    spop_rx_if  rx ();
    spop_res_if res ();

    sensor_packet_odometry_parser_core #(.CORDIC_STEPS(Steps)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx.sink),
        .o_res   (res.source)
    );

    odometry_board board;
    int  idle_cycles;
    bit  quiet;
    bit  pressure_done;
    int  stall_left;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offers one word and waits for it to be taken.
    task automatic send_byte(input logic [7:0] b, input logic eop);
        int g;
        rx.valid <= 1'b1;
        rx.rx_byte <= b;
        rx.end_of_packet <= eop;
        do @(posedge i_clk); while (!rx.ready);
        board.note_byte(b, eop);
        g = gap_len();
        if (g > 0) begin
            rx.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic send_packet(input int len, input bit fixed, input logic [7:0] fill,
                               input logic [15:0] travel, input logic [15:0] deg);
        logic [7:0] b;
        int i;
        quiet = ($urandom_range(0, 4) == 0);
        for (i = 0; i < len; i++) begin
            b = fixed ? fill : 8'($urandom);
            case (i)
                12: b = travel[15:8];
                13: b = travel[7:0];
                14: b = deg[15:8];
                15: b = deg[7:0];
                default: ;
            endcase
            send_byte(b, i == len - 1);
        end
    endtask

    // Result side: random stalls, and one long hold-off so the block backs up.
    initial begin
        res.ready = 1'b0;
        stall_left = 0;
        pressure_done = 0;
        forever begin
            @(posedge i_clk);
            if (res.valid && res.ready) begin
                board.check_report({res.status, res.contact_flags, res.motor_button_flags,
                                    res.remote_code, res.charge_status, res.battery_millivolts,
                                    res.battery_milliamps, res.battery_temp,
                                    res.charge_and_capacity, res.pose_x, res.pose_y,
                                    res.pose_heading});
            end
            if (!pressure_done && board.reports_seen == 3) begin
                pressure_done = 1;
                stall_left = LongStall;
            end
            if (stall_left > 0) begin
                stall_left--;
                res.ready <= 1'b0;
            end else begin
                if (!quiet && $urandom_range(0, 9) < 3) stall_left = gap_len();
                res.ready <= (stall_left == 0);
            end
        end
    end

    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((rx.valid && rx.ready) || (res.valid && res.ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WatchMax) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        int n;
        int len;
        board = new();
        quiet = 0;
        i_rst_n = 1'b0;
        rx.valid = 1'b0;
        rx.rx_byte = 8'h00;
        rx.end_of_packet = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: all-zero and all-one packets, extreme distances and angles,
        // short, one-word, overlong and saturating packets.
        send_packet(PacketBytes, 1, 8'h00, 16'h0000, 16'h0000);
        send_packet(PacketBytes, 1, 8'hFF, 16'hFFFF, 16'hFFFF);
        send_packet(PacketBytes, 1, 8'hAA, 16'h7FFF, 16'h7FFF);
        send_packet(PacketBytes, 1, 8'h55, 16'h8000, 16'h8000);
        send_packet(PacketBytes, 0, 8'h00, 16'd1000, 16'd90);
        send_packet(PacketBytes, 0, 8'h00, 16'd1000, 16'd180);
        send_packet(PacketBytes, 0, 8'h00, -16'sd1000, -16'sd90);
        send_packet(1, 0, 8'h00, 16'h0000, 16'h0000);
        send_packet(PacketBytes - 1, 0, 8'h00, 16'd50, 16'd10);
        send_packet(PacketBytes + 1, 0, 8'h00, 16'd50, 16'd10);
        send_packet(40, 0, 8'h00, 16'd50, 16'd10);
        send_packet(PacketBytes, 0, 8'h00, 16'd300, 16'd45);

        // Random: mostly well-formed packets with plausible motion, some with
        // wild values, and some of a random length from 1 to 40 words.
        for (n = 0; n < 16; n++) begin
            len = PacketBytes;
            if ($urandom_range(0, 9) == 0) len = $urandom_range(1, 40);
            if ($urandom_range(0, 3) == 0)
                send_packet(len, 0, 8'h00, 16'($urandom), 16'($urandom));
            else
                send_packet(len, 0, 8'h00, 16'($signed($urandom_range(0, 1000)) - 500),
                            16'($signed($urandom_range(0, 360)) - 180));
        end
        rx.valid <= 1'b0;

        while (board.owed.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (board.errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire
